/* rtl/sexl_pkg.sv */
`timescale 1ns / 1ps
// Shared types, character codes and the word classifier for the s-expression lexer.
// No dependencies; imported by every module of the lexer.
package sexl_pkg;

  // input operations
  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // token types
  localparam logic [3:0] TOK_UINT   = 4'd0;
  localparam logic [3:0] TOK_INT    = 4'd1;
  localparam logic [3:0] TOK_FLOAT  = 4'd2;
  localparam logic [3:0] TOK_SYMBOL = 4'd3;
  localparam logic [3:0] TOK_STRING = 4'd4;
  localparam logic [3:0] TOK_LPAREN = 4'd5;
  localparam logic [3:0] TOK_RPAREN = 4'd6;
  localparam logic [3:0] TOK_LBRACK = 4'd7;
  localparam logic [3:0] TOK_RBRACK = 4'd8;
  localparam logic [3:0] TOK_QUOTE  = 4'd9;

  // result kinds
  localparam logic KIND_TEXT   = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  // word classifier states
  localparam logic [2:0] NC_EMPTY = 3'd0;
  localparam logic [2:0] NC_SIGN  = 3'd1;
  localparam logic [2:0] NC_UDIG  = 3'd2;
  localparam logic [2:0] NC_DOT   = 3'd3;
  localparam logic [2:0] NC_FRAC  = 3'd4;
  localparam logic [2:0] NC_SYM   = 3'd5;
  localparam logic [2:0] NC_SDIG  = 3'd6;

  // character codes
  localparam logic [15:0] CH_NUL    = 16'h0000;
  localparam logic [15:0] CH_TAB    = 16'h0009;
  localparam logic [15:0] CH_NL     = 16'h000A;
  localparam logic [15:0] CH_SPACE  = 16'h0020;
  localparam logic [15:0] CH_DQUOTE = 16'h0022;
  localparam logic [15:0] CH_HASH   = 16'h0023;
  localparam logic [15:0] CH_SQUOTE = 16'h0027;
  localparam logic [15:0] CH_LPAREN = 16'h0028;
  localparam logic [15:0] CH_RPAREN = 16'h0029;
  localparam logic [15:0] CH_PLUS   = 16'h002B;
  localparam logic [15:0] CH_MINUS  = 16'h002D;
  localparam logic [15:0] CH_DOT    = 16'h002E;
  localparam logic [15:0] CH_ZERO   = 16'h0030;
  localparam logic [15:0] CH_NINE   = 16'h0039;
  localparam logic [15:0] CH_LBRACK = 16'h005B;
  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_RBRACK = 16'h005D;

  localparam int unsigned LINE_OUT_W = 20;
  localparam int unsigned COL_OUT_W  = 16;
  localparam int unsigned LEN_W      = 16;

  typedef struct packed {
    logic                  kind;
    logic [15:0]           text_char;
    logic [3:0]            token_type;
    logic [LINE_OUT_W-1:0] line_number;
    logic [COL_OUT_W-1:0]  column;
    logic [LEN_W-1:0]      length;
    logic                  last;
  } res_t;

  // up to two results per item, written into the queue together
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [2:0] classify_next(logic [2:0] s, logic [15:0] c);
    logic digit;
    logic [2:0] nxt;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    case (s)
      NC_EMPTY: begin
        if (c == CH_PLUS || c == CH_MINUS) nxt = NC_SIGN;
        else nxt = digit ? NC_UDIG : NC_SYM;
      end
      NC_SIGN: nxt = digit ? NC_SDIG : NC_SYM;
      NC_UDIG, NC_SDIG: begin
        if (digit) nxt = s;
        else nxt = (c == CH_DOT) ? NC_DOT : NC_SYM;
      end
      NC_DOT, NC_FRAC: nxt = digit ? NC_FRAC : NC_SYM;
      default: nxt = NC_SYM;
    endcase
    return nxt;
  endfunction

  function automatic logic [3:0] word_type(logic [2:0] s);
    logic [3:0] t;
    case (s)
      NC_UDIG: t = TOK_UINT;
      NC_SDIG: t = TOK_INT;
      NC_FRAC: t = TOK_FLOAT;
      default: t = TOK_SYMBOL;
    endcase
    return t;
  endfunction

endpackage

/* rtl/sexl_lexer.sv */
`timescale 1ns / 1ps
// Input stage, lexer state and the per-character update logic.
// Depends on sexl_pkg; feeds sexl_rqueue.
module sexl_lexer
  import sexl_pkg::*;
#(
  parameter int unsigned LINE_BITS   = 20,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] ch_i,
  input  logic        room_i,
  output push_t       push_o
);

  logic                   stg_v_q;
  logic [1:0]             op_q;
  logic [15:0]            ch_q;
  logic                   go;

  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic [LEN_W-1:0]       plen_q, plen_d;
  logic                   in_str_q, in_str_d;
  logic                   in_cmt_q, in_cmt_d;
  logic                   bslash_q, bslash_d;
  logic [2:0]             nc_q, nc_d;

  logic [31:0]            line_w;
  logic [COLUMN_BITS-1:0] word_col, str_col, col_inc;
  logic [31:0]            word_col_w, str_col_w, cur_col_w;
  res_t                   word_rec, text_rec, str_rec, single_rec;
  logic                   word_hit;
  logic [3:0]             single_type;
  push_t                  push;

  assign go         = stg_v_q && room_i;
  assign in_stall_o = stg_v_q && !room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      stg_v_q <= 1'b1;
    end else if (go) begin
      stg_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q <= op_i;
      ch_q <= ch_i;
    end
  end

  assign col_inc    = col_q + COLUMN_BITS'(1);
  assign line_w     = 32'(line_q);
  assign word_col   = col_q - COLUMN_BITS'(plen_q);
  // a string's start column covers its quotes; col_inc already counts the closing one
  assign str_col    = col_inc - COLUMN_BITS'(plen_q) - COLUMN_BITS'(2);
  assign word_col_w = 32'(word_col);
  assign str_col_w  = 32'(str_col);
  assign cur_col_w  = 32'(col_q);
  assign word_hit   = (nc_q != NC_EMPTY);

  always_comb begin
    case (ch_q)
      CH_LPAREN: single_type = TOK_LPAREN;
      CH_RPAREN: single_type = TOK_RPAREN;
      CH_LBRACK: single_type = TOK_LBRACK;
      CH_RBRACK: single_type = TOK_RBRACK;
      default:   single_type = TOK_QUOTE;
    endcase
  end

  always_comb begin
    word_rec             = '0;
    word_rec.kind        = KIND_RECORD;
    word_rec.token_type  = word_type(nc_q);
    word_rec.line_number = line_w[LINE_OUT_W-1:0];
    word_rec.column      = word_col_w[COL_OUT_W-1:0];
    word_rec.length      = plen_q;

    text_rec           = '0;
    text_rec.kind      = KIND_TEXT;
    text_rec.text_char = ch_q;

    str_rec             = '0;
    str_rec.kind        = KIND_RECORD;
    str_rec.token_type  = TOK_STRING;
    str_rec.line_number = line_w[LINE_OUT_W-1:0];
    str_rec.column      = str_col_w[COL_OUT_W-1:0];
    str_rec.length      = plen_q;

    single_rec             = '0;
    single_rec.kind        = KIND_RECORD;
    single_rec.token_type  = single_type;
    single_rec.line_number = line_w[LINE_OUT_W-1:0];
    single_rec.column      = cur_col_w[COL_OUT_W-1:0];
  end

  always_comb begin
    line_d   = line_q;
    col_d    = col_q;
    plen_d   = plen_q;
    in_str_d = in_str_q;
    in_cmt_d = in_cmt_q;
    bslash_d = bslash_q;
    nc_d     = nc_q;
    push     = '0;

    case (op_q)
      OP_FLUSH: begin
        if (word_hit) begin
          push.cnt = 2'd1;
          push.r0  = word_rec;
        end
        nc_d     = NC_EMPTY;
        plen_d   = '0;
        in_str_d = 1'b0;
        in_cmt_d = 1'b0;
        bslash_d = 1'b0;
      end
      OP_CLEAR: begin
        line_d = LINE_BITS'(1);
        col_d  = COLUMN_BITS'(1);
      end
      OP_CHAR: begin
        if (in_cmt_q) begin
          if (ch_q == CH_NL || ch_q == CH_NUL) begin
            in_cmt_d = 1'b0;
            line_d   = line_q + LINE_BITS'(1);
            col_d    = COLUMN_BITS'(1);
          end
        end else if (in_str_q) begin
          if (ch_q == CH_DQUOTE && !bslash_q) begin
            col_d    = col_inc;
            push.cnt = 2'd1;
            push.r0  = str_rec;
            plen_d   = '0;
            in_str_d = 1'b0;
            bslash_d = 1'b0;
          end else if (ch_q == CH_NL) begin
            line_d   = line_q + LINE_BITS'(1);
            col_d    = COLUMN_BITS'(1);
            bslash_d = 1'b0;
          end else begin
            push.cnt = 2'd1;
            push.r0  = text_rec;
            plen_d   = plen_q + LEN_W'(1);
            col_d    = col_inc;
            bslash_d = (ch_q == CH_BSLASH);
          end
        end else begin
          // separators flush the pending word first
          case (ch_q)
            CH_HASH, CH_DQUOTE, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
            CH_SQUOTE, CH_NL, CH_NUL, CH_TAB, CH_SPACE: begin
              if (word_hit) begin
                push.cnt = 2'd1;
                push.r0  = word_rec;
              end
              nc_d   = NC_EMPTY;
              plen_d = '0;
            end
            default: ;
          endcase

          case (ch_q)
            CH_HASH: in_cmt_d = 1'b1;
            CH_DQUOTE: begin
              col_d    = col_inc;
              in_str_d = 1'b1;
              bslash_d = 1'b0;
            end
            CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_SQUOTE: begin
              if (word_hit) begin
                push.cnt = 2'd2;
                push.r1  = single_rec;
              end else begin
                push.cnt = 2'd1;
                push.r0  = single_rec;
              end
              col_d = col_inc;
            end
            CH_NL: begin
              line_d = line_q + LINE_BITS'(1);
              col_d  = COLUMN_BITS'(1);
            end
            CH_NUL, CH_TAB, CH_SPACE: col_d = col_inc;
            default: begin
              push.cnt = 2'd1;
              push.r0  = text_rec;
              nc_d     = classify_next(nc_q, ch_q);
              plen_d   = plen_q + LEN_W'(1);
              col_d    = col_inc;
            end
          endcase
        end
      end
      default: ;
    endcase

    // mark the final result of this item
    if (push.cnt == 2'd2) begin
      push.r1.last = 1'b1;
    end else if (push.cnt == 2'd1) begin
      push.r0.last = 1'b1;
    end
    if (!go) begin
      push.cnt = 2'd0;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q   <= LINE_BITS'(1);
      col_q    <= COLUMN_BITS'(1);
      plen_q   <= '0;
      in_str_q <= 1'b0;
      in_cmt_q <= 1'b0;
      bslash_q <= 1'b0;
      nc_q     <= NC_EMPTY;
    end else if (go) begin
      line_q   <= line_d;
      col_q    <= col_d;
      plen_q   <= plen_d;
      in_str_q <= in_str_d;
      in_cmt_q <= in_cmt_d;
      bslash_q <= bslash_d;
      nc_q     <= nc_d;
    end
  end

endmodule

/* rtl/sexl_rqueue.sv */
`timescale 1ns / 1ps
// Four-entry result queue: takes up to two results per cycle, hands out one unless out_stall_i is high.
// Depends on sexl_pkg; driven by sexl_lexer.
module sexl_rqueue
  import sexl_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output res_t  head_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  res_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q, wr_nxt;
  logic [CNT_W-1:0] cnt_q;
  logic             pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  // room for a full pair of results
  assign room_o      = (cnt_q <= CNT_W'(DEPTH - 2));
  assign head_o      = mem_q[rd_q];
  assign wr_nxt      = wr_q + PTR_W'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nxt] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PTR_W'(push_i.cnt);
      if (pop) begin
        rd_q <= rd_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(push_i.cnt) - CNT_W'(pop);
    end
  end

endmodule

/* rtl/s_expression_tokenizer_core.sv */
`timescale 1ns / 1ps
// Top level of the s-expression lexer: input stage and state in sexl_lexer,
// results in sexl_rqueue. Depends on sexl_pkg.
//
// One 16-bit character (or a flush or clear operation) is taken per cycle
// unless in_stall_o is high. Characters of a word or string body are echoed
// as text results; each finished token gives a record with type, line, start
// column and length. An item is held in the input register, and its results
// go into the result queue. Most items make at most one result and run at
// one item per cycle while the output is not stalled; a bracket or quote that
// ends a word makes two results. The four-entry result queue sets the pace:
// a new item is processed only while two entries are free.
module s_expression_tokenizer_core
  import sexl_pkg::*;
#(
  parameter int unsigned LINE_BITS   = 20,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [15:0] text_char_o,
  output logic [3:0]  token_type_o,
  output logic [19:0] line_number_o,
  output logic [15:0] column_o,
  output logic [15:0] length_o,
  output logic        last_o
);

  push_t push;
  logic  room;
  res_t  head;

  sexl_lexer #(
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .op_i      (op_i),
    .ch_i      (ch_i),
    .room_i    (room),
    .push_o    (push)
  );

  sexl_rqueue u_rqueue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .head_o     (head)
  );

  assign kind_o        = head.kind;
  assign text_char_o   = head.text_char;
  assign token_type_o  = head.token_type;
  assign line_number_o = head.line_number;
  assign column_o      = head.column;
  assign length_o      = head.length;
  assign last_o        = head.last;

endmodule

/* tb/sexl_token_checker.sv */
`timescale 1ns / 1ps
// Token checker for the s-expression lexer: tracks the lexer state for every accepted item,
// queues the results it should give and compares each accepted result. Depends on sexl_pkg.
module sexl_token_checker
  import sexl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  op_i,
  input  logic [15:0] ch_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        kind_i,
  input  logic [15:0] text_char_i,
  input  logic [3:0]  token_type_i,
  input  logic [19:0] line_number_i,
  input  logic [15:0] column_i,
  input  logic [15:0] length_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          open_count_o
);

  logic [19:0] line_cnt;
  logic [15:0] col_cnt;
  logic [15:0] tok_len;
  logic        in_str;
  logic        in_cmt;
  logic        after_bslash;
  logic [2:0]  word_cls;

  // results of the item being predicted, at most two
  res_t item_res [2];
  int   item_cnt;
  res_t expected_tokens [$];

  function automatic string show(res_t r);
    return $sformatf("kind %0d char %04h type %0d line %0d col %0d len %0d last %0d",
                     r.kind, r.text_char, r.token_type, r.line_number, r.column,
                     r.length, r.last);
  endfunction

  function automatic logic [2:0] step_class(logic [2:0] s, logic [15:0] c);
    logic       is_digit;
    logic [2:0] n;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    n = NC_SYM;
    if (s == NC_EMPTY) begin
      if (c == CH_PLUS || c == CH_MINUS) n = NC_SIGN;
      else if (is_digit) n = NC_UDIG;
    end else if (s == NC_SIGN) begin
      if (is_digit) n = NC_SDIG;
    end else if (s == NC_UDIG || s == NC_SDIG) begin
      if (is_digit) n = s;
      else if (c == CH_DOT) n = NC_DOT;
    end else if (s == NC_DOT || s == NC_FRAC) begin
      if (is_digit) n = NC_FRAC;
    end
    return n;
  endfunction

  task automatic emit(logic k, logic [15:0] c, logic [3:0] t, logic [19:0] ln,
                      logic [15:0] cl, logic [15:0] len);
    res_t r;
    r = '0;
    r.kind = k;
    r.text_char = c;
    r.token_type = t;
    r.line_number = ln;
    r.column = cl;
    r.length = len;
    item_res[item_cnt] = r;
    item_cnt++;
  endtask

  task automatic flush_word();
    logic [3:0] t;
    if (word_cls != NC_EMPTY) begin
      if (word_cls == NC_UDIG) t = TOK_UINT;
      else if (word_cls == NC_SDIG) t = TOK_INT;
      else if (word_cls == NC_FRAC) t = TOK_FLOAT;
      else t = TOK_SYMBOL;
      emit(KIND_RECORD, CH_NUL, t, line_cnt, col_cnt - tok_len, tok_len);
      word_cls = NC_EMPTY;
      tok_len = '0;
    end
  endtask

  task automatic next_line();
    line_cnt = line_cnt + 20'd1;
    col_cnt = 16'd1;
  endtask

  task automatic predict_tokens(logic [1:0] op, logic [15:0] c);
    item_cnt = 0;
    if (op == OP_FLUSH) begin
      flush_word();
      in_str = 1'b0;
      in_cmt = 1'b0;
      after_bslash = 1'b0;
      tok_len = '0;
    end else if (op == OP_CLEAR) begin
      line_cnt = 20'd1;
      col_cnt = 16'd1;
    end else if (op == OP_CHAR) begin
      if (in_cmt) begin
        if (c == CH_NL || c == CH_NUL) begin
          in_cmt = 1'b0;
          next_line();
        end
      end else if (in_str) begin
        if (c == CH_DQUOTE && !after_bslash) begin
          col_cnt++;
          // start column is that of the opening quote
          emit(KIND_RECORD, CH_NUL, TOK_STRING, line_cnt, col_cnt - tok_len - 16'd2, tok_len);
          tok_len = '0;
          in_str = 1'b0;
          after_bslash = 1'b0;
        end else if (c == CH_NL) begin
          next_line();
          after_bslash = 1'b0;
        end else begin
          emit(KIND_TEXT, c, '0, '0, '0, '0);
          tok_len++;
          col_cnt++;
          after_bslash = (c == CH_BSLASH);
        end
      end else begin
        case (c)
          CH_HASH: begin
            flush_word();
            in_cmt = 1'b1;
          end
          CH_DQUOTE: begin
            flush_word();
            col_cnt++;
            in_str = 1'b1;
            after_bslash = 1'b0;
            tok_len = '0;
          end
          CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_SQUOTE: begin
            flush_word();
            emit(KIND_RECORD, CH_NUL,
                 (c == CH_LPAREN) ? TOK_LPAREN : (c == CH_RPAREN) ? TOK_RPAREN :
                 (c == CH_LBRACK) ? TOK_LBRACK : (c == CH_RBRACK) ? TOK_RBRACK : TOK_QUOTE,
                 line_cnt, col_cnt, '0);
            col_cnt++;
          end
          CH_NL: begin
            flush_word();
            next_line();
          end
          CH_NUL, CH_TAB, CH_SPACE: begin
            flush_word();
            col_cnt++;
          end
          default: begin
            emit(KIND_TEXT, c, '0, '0, '0, '0);
            word_cls = step_class(word_cls, c);
            tok_len++;
            col_cnt++;
          end
        endcase
      end
    end
    if (item_cnt > 0) item_res[item_cnt-1].last = 1'b1;
    for (int i = 0; i < item_cnt; i++) begin
      expected_tokens.insert(expected_tokens.size(), item_res[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      line_cnt = 20'd1;
      col_cnt = 16'd1;
      tok_len = '0;
      in_str = 1'b0;
      in_cmt = 1'b0;
      after_bslash = 1'b0;
      word_cls = NC_EMPTY;
      expected_tokens.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '0;
        got.kind = kind_i;
        got.text_char = text_char_i;
        got.token_type = token_type_i;
        got.line_number = line_number_i;
        got.column = column_i;
        got.length = length_i;
        got.last = last_i;
        if (expected_tokens.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result: %s", show(got));
          fail_count_o++;
        end else begin
          want = expected_tokens.pop_front();
          if (got.kind !== want.kind || got.text_char !== want.text_char ||
              got.token_type !== want.token_type || got.line_number !== want.line_number ||
              got.column !== want.column || got.length !== want.length ||
              got.last !== want.last) begin
            if (fail_count_o < 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
            fail_count_o++;
          end
        end
      end
      // an item accepted at this edge cannot have results out yet
      if (in_valid_i && !in_stall_i) predict_tokens(op_i, ch_i);
    end
    open_count_o = expected_tokens.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Top of the s-expression lexer testbench: clock, reset, item and stall stimulus, verdict.
// Depends on sexl_pkg, s_expression_tokenizer_core and sexl_token_checker.
module tb_top;
  import sexl_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEM_TARGET = 1200;
  localparam int LONG_WORD   = 64;
  localparam int SETTLE      = 8;

  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam logic [15:0] CH_LOWER_A = 16'h0061;
  localparam logic [15:0] CH_LOWER_X = 16'h0078;
  localparam logic [15:0] CH_MAX     = 16'hFFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  op = OP_CHAR;
  logic [15:0] ch = CH_NUL;
  logic        out_stall = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic        kind;
  logic [15:0] text_char;
  logic [3:0]  token_type;
  logic [19:0] line_number;
  logic [15:0] column;
  logic [15:0] length;
  logic        last;

  logic src_idle = 1'b1;
  logic snk_idle = 1'b1;
  int   stall_left = 0;
  int   stall_roll;
  int   cycle_count = 0;
  int   sent_items = 0;
  int   fail_count;
  int   open_count;

  always #5 clk = ~clk;

  s_expression_tokenizer_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .op_i          (op),
    .ch_i          (ch),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .kind_o        (kind),
    .text_char_o   (text_char),
    .token_type_o  (token_type),
    .line_number_o (line_number),
    .column_o      (column),
    .length_o      (length),
    .last_o        (last)
  );

  sexl_token_checker u_token_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .op_i          (op),
    .ch_i          (ch),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .kind_i        (kind),
    .text_char_i   (text_char),
    .token_type_i  (token_type),
    .line_number_i (line_number),
    .column_i      (column),
    .length_i      (length),
    .last_i        (last),
    .fail_count_o  (fail_count),
    .open_count_o  (open_count)
  );

  // result side: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (stall_left == 0 && snk_idle) begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 3) stall_left = $urandom_range(10, 40);
      else if (stall_roll < 25) stall_left = $urandom_range(1, 3);
    end
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // called at a rising edge, returns at the edge that accepts the item
  task automatic send_item(input logic [1:0] item_op, input logic [15:0] item_ch);
    int gap;
    int roll;
    gap = 0;
    if (src_idle) begin
      roll = $urandom_range(0, 99);
      if (roll >= 93) gap = $urandom_range(8, 30);
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= item_op;
    ch <= item_ch;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    if (item_op != OP_UNUSED) sent_items++;
  endtask

  task automatic send_char(input logic [15:0] c);
    send_item(OP_CHAR, c);
  endtask

  // hold the sender until every expected result is out
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (open_count != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [15:0] word_char();
    logic [15:0] c;
    case ($urandom_range(0, 3))
      0: c = CH_ZERO + 16'($urandom_range(0, 9));
      1: c = ($urandom_range(0, 2) == 0) ? CH_PLUS : ($urandom_range(0, 1) ? CH_MINUS : CH_DOT);
      2: c = CH_LOWER_A + 16'($urandom_range(0, 25));
      default: c = 16'($urandom);
    endcase
    if (c inside {CH_NUL, CH_TAB, CH_NL, CH_SPACE, CH_DQUOTE, CH_HASH, CH_SQUOTE,
                  CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK})
      c = CH_LOWER_X;
    return c;
  endfunction

  task automatic send_chunk();
    int          roll;
    int          shape;
    logic [15:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      // 0 uint, 1 signed int, 2 float, 3 loose word
      shape = $urandom_range(0, 3);
      if (shape == 1 || (shape == 2 && $urandom_range(0, 1) == 1))
        send_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      if (shape == 3) begin
        repeat ($urandom_range(1, 6)) send_char(word_char());
      end else begin
        repeat ($urandom_range(1, 4)) send_char(CH_ZERO + 16'($urandom_range(0, 9)));
        if (shape == 2) begin
          send_char(CH_DOT);
          repeat ($urandom_range(1, 3)) send_char(CH_ZERO + 16'($urandom_range(0, 9)));
        end
      end
    end else if (roll < 42) begin
      case ($urandom_range(0, 3))
        0: send_char(CH_SPACE);
        1: send_char(CH_TAB);
        2: send_char(CH_NL);
        default: send_char(CH_NUL);
      endcase
    end else if (roll < 57) begin
      case ($urandom_range(0, 4))
        0: send_char(CH_LPAREN);
        1: send_char(CH_RPAREN);
        2: send_char(CH_LBRACK);
        3: send_char(CH_RBRACK);
        default: send_char(CH_SQUOTE);
      endcase
    end else if (roll < 67) begin
      send_char(CH_DQUOTE);
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 5))
          0: begin
            send_char(CH_BSLASH);
            if ($urandom_range(0, 1) == 1) send_char(CH_DQUOTE);
          end
          1: send_char(CH_NL);
          2: send_char(16'($urandom));
          default: send_char(CH_LOWER_A + 16'($urandom_range(0, 25)));
        endcase
      end
      if ($urandom_range(0, 9) == 0) send_item(OP_FLUSH, 16'($urandom));
      else send_char(CH_DQUOTE);
    end else if (roll < 74) begin
      send_char(CH_HASH);
      repeat ($urandom_range(0, 4)) begin
        c = 16'($urandom);
        if (c == CH_NL || c == CH_NUL) c = CH_LOWER_X;
        send_char(c);
      end
      case ($urandom_range(0, 4))
        0: send_char(CH_NUL);
        1: send_item(OP_FLUSH, 16'($urandom));
        default: send_char(CH_NL);
      endcase
    end else if (roll < 78) begin
      send_item(OP_FLUSH, 16'($urandom));
    end else if (roll < 81) begin
      send_item(OP_CLEAR, 16'($urandom));
    end else if (roll < 83) begin
      send_item(OP_UNUSED, 16'($urandom));
    end else begin
      // noise: any code, now and then any operation
      if ($urandom_range(0, 7) == 0) send_item(2'($urandom_range(1, 3)), 16'($urandom));
      else send_char(16'($urandom));
    end
  endtask

  initial begin
    int next_switch;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: number classes, bracket after a word, comment, escapes, flushes
    send_item(OP_CLEAR, CH_NUL);
    send_item(OP_UNUSED, CH_MAX);
    send_char(CH_LPAREN);
    send_char(CH_MINUS);
    send_char(CH_ZERO + 16'd1);
    send_char(CH_DOT);
    send_char(CH_ZERO + 16'd5);
    send_char(CH_RBRACK);
    send_char(CH_PLUS);
    send_char(CH_NINE);
    send_char(CH_TAB);
    send_char(CH_MAX);
    send_char(CH_HASH);
    send_char(CH_LOWER_X);
    send_char(CH_NUL);
    send_char(CH_DQUOTE);
    send_char(CH_BSLASH);
    send_char(CH_DQUOTE);
    send_char(CH_NL);
    send_char(CH_DQUOTE);
    send_char(CH_ZERO);
    send_char(CH_SQUOTE);
    send_char(CH_DQUOTE);
    send_item(OP_FLUSH, CH_MAX);
    send_char(CH_HASH);
    send_item(OP_FLUSH, CH_NUL);
    drain();

    // one long word sent back to back, no idling on either side
    src_idle = 1'b0;
    snk_idle <= 1'b0;
    repeat (LONG_WORD) send_char(CH_LOWER_A);
    send_char(CH_RPAREN);
    drain();

    src_idle = 1'b1;
    snk_idle <= 1'b1;
    sent_items = 0;
    next_switch = 150;
    while (sent_items < ITEM_TARGET) begin
      if (sent_items >= next_switch) begin
        next_switch += 150;
        if ($urandom_range(0, 2) == 0) drain();
        src_idle = ($urandom_range(0, 3) != 0);
        snk_idle <= ($urandom_range(0, 3) != 0);
      end
      send_chunk();
    end
    drain();

    @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sexl_pkg.sv
rtl/sexl_lexer.sv
rtl/sexl_rqueue.sv
rtl/s_expression_tokenizer_core.sv
tb/sexl_token_checker.sv
tb/tb_top.sv
